>>> sv/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared codes and types for the linear probing hash set: operation codes,
// slot tags, result status codes and the slot store write request.
// ----------------------------------------------------------------------------
`default_nettype none

package lphs_pkg;

	localparam int unsigned KEY_W    = 32;
	localparam int unsigned TAG_W    = 2;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned SLOT_W   = 10;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned OUT_W    = 32;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [TAG_W-1:0] TAG_EMPTY   = 2'd0;
	localparam logic [TAG_W-1:0] TAG_LIVE    = 2'd1;
	localparam logic [TAG_W-1:0] TAG_DELETED = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd4;

	// Byte address of the load limit register on the configuration port.
	localparam logic [2:0] ADDR_LOAD_LIMIT = 3'd0;

	// Write request to the slot store; the address travels beside it since
	// its width follows the table size.
	typedef struct packed {
		logic              en;
		logic [TAG_W-1:0]  tag;
		logic [KEY_W-1:0]  key;
	} lphs_wr_t;

endpackage

`default_nettype wire

>>> sv/lphs_store.sv
// ----------------------------------------------------------------------------
// lphs_store
// Slot store: one key memory and one tag memory sharing a write port and a
// read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_store #(
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                              clk,
	input  wire logic [$clog2(DEPTH)-1:0]          rd_addr,
	input  wire lphs_pkg::lphs_wr_t                wr,
	input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
	output logic      [lphs_pkg::TAG_W-1:0]        rd_tag,
	output logic      [lphs_pkg::KEY_W-1:0]        rd_key
);
	import lphs_pkg::*;

	logic [TAG_W-1:0] tag_mem [DEPTH];
	logic [KEY_W-1:0] key_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			tag_mem[wr_addr] <= wr.tag;
			key_mem[wr_addr] <= wr.key;
		end
	end

	always_ff @(posedge clk) begin
		rd_tag <= tag_mem[rd_addr];
		rd_key <= key_mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> sv/linear_probe_hash_set.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Set of nonzero 32-bit keys held in a linear probing hash table.
// ----------------------------------------------------------------------------
// Each input beat carries one operation (insert, look up, remove) on one key;
// each produces exactly one result beat. The home slot is key * 31 modulo
// TABLE_SIZE (a power of two); probing steps one slot a cycle with wrap and
// stops at a live match, at an empty slot or after TABLE_SIZE probes. Removal
// leaves a tombstone. Inserts reuse the first free slot on the path and are
// refused once the live count reaches load_limit or no free slot is found.
// A zero key skips probing and is answered with the ZERO status. The single
// read port of the slot memories allows one probe per cycle. One operation
// is in flight at a time; the next is accepted once the current result has
// moved into the output register, even while that register waits.
// After reset the tag memory is swept to empty, during which s_tready stays
// low; APB writes are taken throughout. When the receiver stalls the result
// beat holds and the block stops after one more.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_set #(
	parameter int unsigned TABLE_SIZE = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] key
	input  wire logic [1:0]  s_tuser,   // [1:0] opcode
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [0] found, [3:1] status,
	                                    // [14:4] live_total, [24:15] slot_index
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import lphs_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd614;

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_CHECK  = 5'b00100,
		S_DECIDE = 5'b01000,
		S_OUT    = 5'b10000
	} state_t;

	state_t state_q;

	logic [IDX_W-1:0]    clr_q;
	logic [IDX_W-1:0]    pos_q;
	logic [IDX_W-1:0]    n_q;
	logic [IDX_W-1:0]    free_q;
	logic                has_free_q;
	logic                present_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [COUNT_W-1:0]  live_q;
	logic [COUNT_W-1:0]  limit_q;

	logic                res_found_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [COUNT_W-1:0]  res_live_q;
	logic [SLOT_W-1:0]   res_slot_q;

	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	lphs_wr_t            wr;
	logic [TAG_W-1:0]    rd_tag;
	logic [KEY_W-1:0]    rd_key;

	logic [KEY_W-1:0]    in_prod;
	logic [IDX_W-1:0]    in_home;
	logic                accept;

	logic                is_live;
	logic                match;
	logic                stop;
	logic                has_free_d;
	logic [IDX_W-1:0]    free_d;

	logic                dec_found;
	logic [STATUS_W-1:0] dec_status;
	logic [COUNT_W-1:0]  dec_live;
	logic [IDX_W-1:0]    dec_slot;
	logic [31:0]         dec_slot_wide;
	logic                out_free;
	logic                cfg_wr;

	lphs_store #(
		.DEPTH (TABLE_SIZE)
	) u_store (
		.clk     (clk),
		.rd_addr (rd_addr),
		.wr      (wr),
		.wr_addr (wr_addr),
		.rd_tag  (rd_tag),
		.rd_key  (rd_key)
	);

	// key * 31 as (key << 5) - key, modulo 2^32
	assign in_prod  = (s_tdata << 5) - s_tdata;
	assign in_home  = in_prod[IDX_W-1:0];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign rd_addr = (state_q == S_CHECK) ? pos_q + 1'b1 : in_home;

	// probe evaluation on the slot read last cycle
	assign is_live    = (rd_tag == TAG_LIVE);
	assign match      = is_live && (rd_key == key_q);
	assign stop       = match || (rd_tag == TAG_EMPTY) || (&n_q);
	assign has_free_d = has_free_q || !is_live;
	assign free_d     = (!has_free_q && !is_live) ? pos_q : free_q;

	always_comb begin
		dec_found  = present_q;
		dec_status = ST_ABSENT;
		dec_live   = live_q;
		dec_slot   = present_q ? pos_q : '0;
		wr         = '0;
		wr_addr    = pos_q;
		wr.key     = key_q;
		case (op_q)
			OP_INSERT: begin
				if (present_q) begin
					dec_status = ST_PRESENT;
				end else if ((live_q >= limit_q) || !has_free_q) begin
					dec_status = ST_FULL;
				end else begin
					dec_status = ST_DONE;
					dec_live   = live_q + 1'b1;
					dec_slot   = free_q;
					wr.en      = (state_q == S_DECIDE);
					wr.tag     = TAG_LIVE;
					wr_addr    = free_q;
				end
			end
			OP_REMOVE: begin
				if (present_q) begin
					dec_status = ST_DONE;
					dec_live   = live_q - 1'b1;
					wr.en      = (state_q == S_DECIDE);
					wr.tag     = TAG_DELETED;
				end
			end
			default: begin
				dec_status = present_q ? ST_PRESENT : ST_ABSENT;
			end
		endcase
		if (state_q == S_CLEAR) begin
			wr.en   = 1'b1;
			wr.tag  = TAG_EMPTY;
			wr_addr = clr_q;
		end
	end

	assign dec_slot_wide = 32'(dec_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			live_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// A new result may load in the cycle the previous one leaves.
			if ((state_q == S_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= (s_tdata == '0) ? S_OUT : S_CHECK;
					end
				end
				S_CHECK: begin
					if (stop) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					live_q  <= dec_live;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= s_tuser;
			key_q        <= s_tdata;
			pos_q        <= in_home;
			n_q          <= '0;
			has_free_q   <= 1'b0;
			free_q       <= '0;
			res_found_q  <= 1'b0;
			res_status_q <= ST_ZERO;
			res_live_q   <= live_q;
			res_slot_q   <= '0;
		end
		if (state_q == S_CHECK) begin
			has_free_q <= has_free_d;
			free_q     <= free_d;
			present_q  <= match;
			if (!stop) begin
				pos_q <= pos_q + 1'b1;
				n_q   <= n_q + 1'b1;
			end
		end
		if (state_q == S_DECIDE) begin
			res_found_q  <= dec_found;
			res_status_q <= dec_status;
			res_live_q   <= dec_live;
			res_slot_q   <= dec_slot_wide[SLOT_W-1:0];
		end
		if ((state_q == S_OUT) && out_free) begin
			m_tdata_q <= {7'd0, res_slot_q, res_live_q, res_status_q, res_found_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// configuration: one register, load_limit, at word 0
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_LOAD_LIMIT[2]) ? {21'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr && (paddr[2] == ADDR_LOAD_LIMIT[2])) begin
			limit_q <= pwdata[COUNT_W-1:0];
		end
	end

endmodule

`default_nettype wire
